[hw/rtl/delimiter_character_stuffer_core_assert.svh]
// Assertion macros for the delimiter character stuffer.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef DELIMITER_CHARACTER_STUFFER_CORE_ASSERT_SVH
`define DELIMITER_CHARACTER_STUFFER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, disabled while the active-low reset is asserted.
`define DCS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dcs assertion failed");
// Clocked check that also holds during reset.
`define DCS_ASSERT_NORST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("dcs assertion failed");
`else
`define DCS_ASSERT(lbl, clk, rst_n, prop)
`define DCS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

[hw/rtl/dcs_pkg.sv]
// Shared types, constants and helpers for the delimiter character stuffer.
// No dependencies; imported by every module of the block.
package dcs_pkg;

	localparam int MaxDelim = 8;
	localparam int DelimW   = 8 * MaxDelim;
	localparam int CfgIdxW  = 2;
	localparam int QDepth   = 4;
	localparam int QPtrW    = 2;
	localparam int QCntW    = 3;
	localparam int WinW     = DelimW - 8;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_DELIM_BYTES = 2'd0,
		CFG_DELIM_LEN   = 2'd1,
		CFG_START_MARK  = 2'd2,
		CFG_END_MARK    = 2'd3
	} cfg_idx_t;

	// Live configuration; len is already clamped to 1..MaxDelim.
	typedef struct packed {
		logic [DelimW-1:0] delim;
		logic [3:0]        len;
		logic [7:0]        start_mark;
		logic [7:0]        end_mark;
	} dcs_cfg_t;

	// One classified input item, front to back.
	typedef struct packed {
		logic [7:0] data;
		logic       opens_frame;
		logic       match;
		logic       last;
	} dcs_cmd_t;

	function automatic logic [3:0] eff_len(input logic [3:0] raw);
		logic [3:0] r;
		r = raw;
		if (raw == 4'd0) r = 4'd1;
		else if (raw > 4'(MaxDelim)) r = 4'(MaxDelim);
		return r;
	endfunction

endpackage

[hw/rtl/dcs_front.sv]
// Front end: accepts input transfers, tracks the match window, classifies.
// Depends on dcs_pkg.
module dcs_front import dcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dcs_cfg_t   cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       message_end,
	input  logic       q_full,
	output logic       q_push,
	output dcs_cmd_t   q_cmd
);

	logic [WinW-1:0]   window_q;
	logic [3:0]        since_q;
	logic              start_q;
	logic [WinW-1:0]   win_eff;
	logic [3:0]        since_eff;
	logic [DelimW-1:0] hist;
	logic [3:0]        count;
	logic              match;
	logic [2:0]        ago;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// a new frame starts with an empty window
	assign win_eff   = start_q ? '0 : window_q;
	assign since_eff = start_q ? 4'd0 : since_q;
	assign hist      = {win_eff, data_byte};
	assign count     = (since_eff >= 4'(MaxDelim)) ? 4'(MaxDelim) : since_eff + 4'd1;

	always_comb begin
		match = (count >= cfg.len);
		ago   = '0;
		for (int k = 0; k < MaxDelim; k++) begin
			ago = 3'(cfg.len - 4'd1 - 4'(k));
			if ((4'(k) < cfg.len) && (hist[ago*8 +: 8] != cfg.delim[k*8 +: 8])) begin
				match = 1'b0;
			end
		end
	end

	assign q_cmd.data        = data_byte;
	assign q_cmd.opens_frame = start_q;
	assign q_cmd.match       = match;
	assign q_cmd.last        = message_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			since_q  <= 4'(MaxDelim);
			start_q  <= 1'b1;
		end else if (q_push) begin
			window_q <= hist[WinW-1:0];
			since_q  <= match ? 4'd0 : count;
			start_q  <= message_end;
		end
	end

endmodule

[hw/rtl/dcs_queue.sv]
// Short command queue between front and back ends.
// Depends on dcs_pkg.
module dcs_queue import dcs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  dcs_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output dcs_cmd_t head,
	output logic     empty
);

	dcs_cmd_t         mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	assign full  = (cnt_q == QCntW'(QDepth));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[hw/rtl/dcs_back.sv]
// Back end: expands queued commands into the stuffed byte stream.
// Depends on dcs_pkg and delimiter_character_stuffer_core_assert.svh.
`include "delimiter_character_stuffer_core_assert.svh"
module dcs_back import dcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dcs_cfg_t   cfg,
	input  dcs_cmd_t   head,
	input  logic       q_empty,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end
);

	typedef enum logic [5:0] {
		ST_HEAD  = 6'b000001,
		ST_ODLM  = 6'b000010,
		ST_DATA  = 6'b000100,
		ST_MDLM  = 6'b001000,
		ST_CDLM  = 6'b010000,
		ST_EMARK = 6'b100000
	} st_t;

	st_t        st_q, st_d;
	logic [2:0] k_q, k_d;
	logic       adv, emit, k_end, done;
	logic [7:0] nxt_byte, delim_k;
	logic       nxt_fend;
	logic       out_valid_q, run_last_q, frame_end_q;
	logic [7:0] out_byte_q;

	// output register frees whenever it is empty or being taken
	assign adv     = !out_valid_q || out_ready;
	assign emit    = adv && !q_empty;
	assign delim_k = cfg.delim[k_q*8 +: 8];
	assign k_end   = ({1'b0, k_q} == (cfg.len - 4'd1));

	always_comb begin
		st_d     = st_q;
		k_d      = k_q;
		nxt_byte = head.data;
		nxt_fend = 1'b0;
		done     = 1'b0;
		case (st_q)
			ST_HEAD, ST_DATA: begin
				if ((st_q == ST_HEAD) && head.opens_frame) begin
					nxt_byte = cfg.start_mark;
					st_d     = ST_ODLM;
					k_d      = '0;
				end else begin
					nxt_byte = head.data;
					k_d      = '0;
					if (head.match)     st_d = ST_MDLM;
					else if (head.last) st_d = ST_CDLM;
					else                done = 1'b1;
				end
			end
			ST_ODLM: begin
				nxt_byte = delim_k;
				if (k_end) st_d = ST_DATA;
				else       k_d  = k_q + 3'd1;
			end
			ST_MDLM: begin
				nxt_byte = delim_k;
				if (!k_end) begin
					k_d = k_q + 3'd1;
				end else if (head.last) begin
					st_d = ST_CDLM;
					k_d  = '0;
				end else begin
					done = 1'b1;
				end
			end
			ST_CDLM: begin
				nxt_byte = delim_k;
				if (k_end) st_d = ST_EMARK;
				else       k_d  = k_q + 3'd1;
			end
			ST_EMARK: begin
				nxt_byte = cfg.end_mark;
				nxt_fend = 1'b1;
				done     = 1'b1;
			end
			default: begin
				st_d = ST_HEAD;
			end
		endcase
		if (done) st_d = ST_HEAD;
	end

	assign q_pop = emit && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_HEAD;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv)  out_valid_q <= !q_empty;
			if (emit) begin
				st_q <= st_d;
				k_q  <= k_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= nxt_byte;
			run_last_q  <= done;
			frame_end_q <= nxt_fend;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

	`DCS_ASSERT(a_pop_marks_last, clk, arst_n, q_pop |=> out_valid && run_last)
	`DCS_ASSERT(a_fend_is_last, clk, arst_n, out_valid && frame_end |-> run_last)
	`DCS_ASSERT(a_mid_run_busy, clk, arst_n, out_valid && !run_last |-> st_q != ST_HEAD)

endmodule

[hw/rtl/delimiter_character_stuffer_core.sv]
// Delimiter character stuffer, top level: config registers, front, queue, back.
// Depends on dcs_pkg, dcs_front, dcs_queue, dcs_back.
//
// Usage:
//  - Input channel (in_valid/in_ready): one message byte per transfer,
//    message_end set on the last byte of a message.
//  - Output channel (out_valid/out_ready): one frame byte per transfer;
//    run_last flags the final byte caused by an input, frame_end the end mark.
//  - Frame: start mark, delimiter, message bytes (each delimiter occurrence
//    doubled), delimiter, end mark.
//  - Config port: cfg_write_en/cfg_index/cfg_data write a register at once;
//    write only while the block is idle.
//  - Path: an accepted input is written into the queue, and the back end
//    then loads the output register from the queue head.
//  - Throughput: the back end emits one byte per cycle unless out_ready stalls it;
//    an input adds 1+len bytes on frame open, len on a doubled delimiter and
//    len+1 on message end. Inputs go back to back into a 4-entry queue until full.
//  - A stalled receiver holds the output register; the queue keeps filling.
//  - Reset: registers return to defaults (length 1, marks S and E), the queue
//    empties and the next byte opens a new frame.
module delimiter_character_stuffer_core import dcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DelimW-1:0]  cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               message_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               frame_end
);

	logic [DelimW-1:0] delim_q;
	logic [3:0]        len_q;
	logic [7:0]        start_mark_q;
	logic [7:0]        end_mark_q;
	dcs_cfg_t          cfg;

	logic     q_full, q_empty, q_push, q_pop;
	dcs_cmd_t q_cmd, q_head;

	// register file; the length is clamped once here for both ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q      <= '0;
			len_q        <= 4'd1;
			start_mark_q <= 8'd83;
			end_mark_q   <= 8'd69;
		end else if (cfg_write_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DELIM_BYTES: delim_q      <= cfg_data;
				CFG_DELIM_LEN:   len_q        <= cfg_data[3:0];
				CFG_START_MARK:  start_mark_q <= cfg_data[7:0];
				CFG_END_MARK:    end_mark_q   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.delim      = delim_q;
	assign cfg.len        = eff_len(len_q);
	assign cfg.start_mark = start_mark_q;
	assign cfg.end_mark   = end_mark_q;

	// front: match detection and classification
	dcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.message_end (message_end),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	// decouples input acceptance from output bursts
	dcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// back: byte sequencer with registered output
	dcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

endmodule
